[src/imu_sample_scale_and_tilt_macros.svh]
// Assertion macros for the IMU scaler.
`ifndef IMU_SAMPLE_SCALE_AND_TILT_MACROS_SVH
`define IMU_SAMPLE_SCALE_AND_TILT_MACROS_SVH

// Same-cycle implication, checked on clk, off during reset.
`define IMU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off during reset.
`define IMU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/imu_sst_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package imu_sst_pkg;

  localparam int SQRT_STEPS   = 32;
  localparam int CORDIC_STEPS = 24;
  // capture, squares, sums, root steps, CORDIC steps, output register
  localparam int PIPE_DEPTH   = 3 + SQRT_STEPS + CORDIC_STEPS + 1;

  localparam int CW = 49;  // CORDIC x/y width
  localparam int ZW = 30;  // angle accumulator width, 20 fractional bits

  localparam logic signed [17:0] ANGLE_LIMIT = 18'sd23040;

  localparam logic CFG_ACCEL_RANGE = 1'b0;
  localparam logic CFG_GYRO_RANGE  = 1'b1;

  typedef struct packed {
    logic [27:0] rate_z_dps;
    logic [27:0] rate_y_dps;
    logic [27:0] rate_x_dps;
    logic [20:0] accel_z_g;
    logic [20:0] accel_y_g;
    logic [20:0] accel_x_g;
  } scaled_t;

  // atan(2^-i) in degrees, 20 fractional bits
  function automatic logic [26:0] atan_q20(input logic [4:0] i);
    logic [26:0] v;
    case (i)
      5'd0:  v = 27'd47185920;
      5'd1:  v = 27'd27855475;
      5'd2:  v = 27'd14718068;
      5'd3:  v = 27'd7471121;
      5'd4:  v = 27'd3750058;
      5'd5:  v = 27'd1876857;
      5'd6:  v = 27'd938658;
      5'd7:  v = 27'd469357;
      5'd8:  v = 27'd234682;
      5'd9:  v = 27'd117342;
      5'd10: v = 27'd58671;
      5'd11: v = 27'd29335;
      5'd12: v = 27'd14668;
      5'd13: v = 27'd7334;
      5'd14: v = 27'd3667;
      5'd15: v = 27'd1833;
      5'd16: v = 27'd917;
      5'd17: v = 27'd458;
      5'd18: v = 27'd229;
      5'd19: v = 27'd115;
      5'd20: v = 27'd57;
      5'd21: v = 27'd29;
      5'd22: v = 27'd14;
      5'd23: v = 27'd7;
      default: v = 27'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[src/imu_sample_scale_and_tilt.sv]
// Pipeline: 3 front stages, 32 root stages, 24 CORDIC stages and an output
//   register between input transfer and result.
// Throughput: one sample per cycle; the whole pipeline holds while a result
//   waits on out_tready.
// Reset: rst_n synchronous, active low; clears valid bits, ranges go to 3.
`timescale 1ns / 1ps
`default_nettype none
`include "imu_sample_scale_and_tilt_macros.svh"
module imu_sample_scale_and_tilt
  import imu_sst_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  // in_tdata, low bit up: accel_x_raw, accel_y_raw, accel_z_raw,
  //   rate_x_raw, rate_y_raw, rate_z_raw (16 bits each)
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [95:0]  in_tdata,
  // out_tdata, low bit up: accel_x_g, accel_y_g, accel_z_g (21),
  //   rate_x_dps, rate_y_dps, rate_z_dps (28), roll_deg, pitch_deg (16), 5 zero bits
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [183:0]      out_tdata,
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [1:0]   cfg_wdata
);

  logic [1:0] accel_range_r;
  logic [1:0] gyro_range_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_range_r <= 2'd3;
      gyro_range_r  <= 2'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACCEL_RANGE: accel_range_r <= cfg_wdata;
        CFG_GYRO_RANGE:  gyro_range_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Whole pipe advances together; it stalls only when a result is stuck.
  logic en;
  logic v_r [PIPE_DEPTH];
  assign en        = !v_r[PIPE_DEPTH-1] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < PIPE_DEPTH; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_tvalid;
      for (int k = 1; k < PIPE_DEPTH; k++) v_r[k] <= v_r[k-1];
    end
  end

  // stage 1: capture and range scaling
  logic signed [15:0] ax, ay, az, gx, gy, gz;
  assign ax = $signed(in_tdata[15:0]);
  assign ay = $signed(in_tdata[31:16]);
  assign az = $signed(in_tdata[47:32]);
  assign gx = $signed(in_tdata[63:48]);
  assign gy = $signed(in_tdata[79:64]);
  assign gz = $signed(in_tdata[95:80]);

  logic [2:0]          ashift;
  logic signed [12:0]  gmul;
  logic signed [28:0]  gxp, gyp, gzp;
  scaled_t             sc_nxt;

  assign ashift = {1'b0, accel_range_r} + 3'd2;
  assign gmul   = $signed({1'b0, 12'(12'd500 << gyro_range_r)});
  assign gxp    = gx * gmul;
  assign gyp    = gy * gmul;
  assign gzp    = gz * gmul;

  always_comb begin
    sc_nxt.accel_x_g  = 21'($signed({{5{ax[15]}}, ax}) <<< ashift);
    sc_nxt.accel_y_g  = 21'($signed({{5{ay[15]}}, ay}) <<< ashift);
    sc_nxt.accel_z_g  = 21'($signed({{5{az[15]}}, az}) <<< ashift);
    sc_nxt.rate_x_dps = gxp[27:0];
    sc_nxt.rate_y_dps = gyp[27:0];
    sc_nxt.rate_z_dps = gzp[27:0];
  end

  scaled_t            side_r [PIPE_DEPTH];
  logic signed [15:0] ax_r, ay_r, az_r;

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= sc_nxt;
      for (int k = 1; k < PIPE_DEPTH; k++) side_r[k] <= side_r[k-1];
      ax_r <= ax;
      ay_r <= ay;
      az_r <= az;
    end
  end

  // stage 2: squares and numerators
  logic signed [31:0] axx, ayy, azz;
  assign axx = ax_r * ax_r;
  assign ayy = ay_r * ay_r;
  assign azz = az_r * az_r;

  logic [30:0]        axx_r, ayy_r, azz_r;
  logic signed [16:0] nroll2_r, npitch2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      axx_r     <= axx[30:0];
      ayy_r     <= ayy[30:0];
      azz_r     <= azz[30:0];
      nroll2_r  <= {ay_r[15], ay_r};
      npitch2_r <= -$signed({ax_r[15], ax_r});  // -(-32768) fits in 17 bits
    end
  end

  // stage 3: sums under the roots
  logic [31:0]        sum_roll_r, sum_pitch_r;
  logic signed [16:0] nroll_d_r  [SQRT_STEPS+1];
  logic signed [16:0] npitch_d_r [SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      sum_roll_r    <= {1'b0, axx_r} + {1'b0, azz_r};
      sum_pitch_r   <= {1'b0, ayy_r} + {1'b0, azz_r};
      nroll_d_r[0]  <= nroll2_r;
      npitch_d_r[0] <= npitch2_r;
      for (int k = 1; k <= SQRT_STEPS; k++) begin
        nroll_d_r[k]  <= nroll_d_r[k-1];
        npitch_d_r[k] <= npitch_d_r[k-1];
      end
    end
  end

  // root pipelines; numerators delayed alongside
  logic [31:0] root_roll, root_pitch;

  imu_sst_sqrt u_sqrt_roll (
    .clk(clk), .en(en), .sum_i(sum_roll_r), .root_o(root_roll)
  );
  imu_sst_sqrt u_sqrt_pitch (
    .clk(clk), .en(en), .sum_i(sum_pitch_r), .root_o(root_pitch)
  );

  logic signed [ZW-1:0] z_roll, z_pitch;
  logic                 zero_roll, zero_pitch;

  imu_sst_cordic u_cordic_roll (
    .clk(clk), .en(en), .root_i(root_roll), .num_i(nroll_d_r[SQRT_STEPS]),
    .z_o(z_roll), .zero_o(zero_roll)
  );
  imu_sst_cordic u_cordic_pitch (
    .clk(clk), .en(en), .root_i(root_pitch), .num_i(npitch_d_r[SQRT_STEPS]),
    .z_o(z_pitch), .zero_o(zero_pitch)
  );

  // last stage: round to 8 fractional bits, clamp, zero vector gives 0
  function automatic logic [15:0] finish(input logic signed [ZW-1:0] z,
                                         input logic zf);
    logic signed [ZW-1:0] zs;
    logic signed [17:0]   r;
    logic signed [17:0]   c;
    zs = z + ZW'(2048);
    r  = zs[ZW-1:12];
    if (r > ANGLE_LIMIT)       c = ANGLE_LIMIT;
    else if (r < -ANGLE_LIMIT) c = -ANGLE_LIMIT;
    else                       c = r;
    return zf ? 16'd0 : c[15:0];
  endfunction

  logic [15:0] roll_r, pitch_r;

  always_ff @(posedge clk) begin
    if (en) begin
      roll_r  <= finish(z_roll, zero_roll);
      pitch_r <= finish(z_pitch, zero_pitch);
    end
  end

  assign out_tvalid = v_r[PIPE_DEPTH-1];
  assign out_tdata  = {5'd0, pitch_r, roll_r, side_r[PIPE_DEPTH-1]};

  // checks
  `IMU_ASSERT_NOW(a_stall_blocks_input, out_tvalid && !out_tready, !in_tready,
    "input accepted while result stalled")
  `IMU_ASSERT_NEXT(a_valid_reaches_out, in_tready && v_r[PIPE_DEPTH-2], out_tvalid,
    "valid bit lost at output stage")
  `IMU_ASSERT_NOW(a_roll_clamped, out_tvalid,
    ($signed(out_tdata[162:147]) <= 16'sd23040) && ($signed(out_tdata[162:147]) >= -16'sd23040),
    "roll outside clamp range")

endmodule
`default_nettype wire

[src/imu_sst_sqrt.sv]
`timescale 1ns / 1ps
`default_nettype none
// floor(sqrt(sum << 32)), one root bit per stage
module imu_sst_sqrt
  import imu_sst_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] sum_i,
  output logic      [31:0] root_o
);

  logic [35:0] r_r [SQRT_STEPS];
  logic [31:0] q_r [SQRT_STEPS];
  logic [31:0] s_r [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam int I = SQRT_STEPS - 1 - k;
    logic [35:0] r_in;
    logic [31:0] q_in;
    logic [31:0] s_in;
    logic [1:0]  pair;
    logic [35:0] rs;
    logic [35:0] t;
    logic        ge;

    if (k == 0) begin : g_first
      assign r_in = '0;
      assign q_in = '0;
      assign s_in = sum_i;
    end else begin : g_next
      assign r_in = r_r[k-1];
      assign q_in = q_r[k-1];
      assign s_in = s_r[k-1];
    end

    // low 32 bits of the radicand are zero
    if (I >= 16) begin : g_hi
      assign pair = s_in[2*(I-16)+1 -: 2];
    end else begin : g_lo
      assign pair = 2'b00;
    end

    assign rs = {r_in[33:0], pair};
    assign t  = {2'b00, q_in, 2'b01};
    assign ge = (rs >= t);

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k] <= ge ? (rs - t) : rs;
        q_r[k] <= {q_in[30:0], ge};
        s_r[k] <= s_in;
      end
    end
  end

  assign root_o = q_r[SQRT_STEPS-1];

endmodule
`default_nettype wire

[src/imu_sst_cordic.sv]
`timescale 1ns / 1ps
`default_nettype none
// Vectoring CORDIC, one micro-rotation per stage
module imu_sst_cordic
  import imu_sst_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic        [31:0]   root_i,
  input  wire logic signed [16:0]   num_i,
  output logic signed      [ZW-1:0] z_o,
  output logic                      zero_o
);

  logic signed [CW-1:0] x_r [CORDIC_STEPS];
  logic signed [CW-1:0] y_r [CORDIC_STEPS];
  logic signed [ZW-1:0] z_r [CORDIC_STEPS];
  logic                 zf_r [CORDIC_STEPS];

  logic signed [CW-1:0] x0;
  logic signed [CW-1:0] y0;
  logic                 zf0;

  assign x0  = $signed({3'b000, root_i, 14'd0});
  assign y0  = $signed({{2{num_i[16]}}, num_i, 30'd0});
  assign zf0 = (root_i == '0) && (num_i == '0);

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    logic signed [CW-1:0] xi;
    logic signed [CW-1:0] yi;
    logic signed [ZW-1:0] zi;
    logic                 fi;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [ZW-1:0] a;

    if (i == 0) begin : g_first
      assign xi = x0;
      assign yi = y0;
      assign zi = '0;
      assign fi = zf0;
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
      assign fi = zf_r[i-1];
    end

    assign xs = xi >>> i;
    assign ys = yi >>> i;
    assign a  = $signed({3'b000, atan_q20(5'(i))});

    always_ff @(posedge clk) begin
      if (en) begin
        if (yi > 0) begin
          x_r[i] <= xi + ys;
          y_r[i] <= yi - xs;
          z_r[i] <= zi + a;
        end else begin
          x_r[i] <= xi - ys;
          y_r[i] <= yi + xs;
          z_r[i] <= zi - a;
        end
        zf_r[i] <= fi;
      end
    end
  end

  assign z_o    = z_r[CORDIC_STEPS-1];
  assign zero_o = zf_r[CORDIC_STEPS-1];

endmodule
`default_nettype wire
